@@ rtl/core/ntdg_pkg.sv @@
// ntdg_pkg: shared constants, codes and transaction types of the digit glyph block
// no dependencies; used by every file under rtl/core

package ntdg_pkg;

	// sizing
	localparam int MAX_DIGITS = 10;
	localparam int HEX_DIGITS = 4;
	localparam int CNT_MAX    = (MAX_DIGITS > HEX_DIGITS) ? MAX_DIGITS : HEX_DIGITS;
	localparam int CNT_W      = $clog2(CNT_MAX + 1);
	localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int ADDR_W     = 3;

	// constants
	localparam logic [3:0]  SUFFIX_GLYPH  = 4'd10;
	localparam logic [23:0] SPACING_RESET = 24'h080000;
	localparam logic [23:0] GAP_RESET     = 24'h040000;
	// floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for any 32-bit n
	localparam logic [31:0] RECIP_TEN     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT   = 35;

	// register index, taken from paddr[2]
	localparam logic REG_SPACING = 1'b0;
	localparam logic REG_GAP     = 1'b1;

	// command codes
	localparam logic [1:0] CMD_DEC    = 2'd0;
	localparam logic [1:0] CMD_HEX    = 2'd1;
	localparam logic [1:0] CMD_SUFFIX = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIGITS,
		ST_SCALE,
		ST_ADJUST,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [30:0]        value;
		logic [3:0]         digit_count;
		logic signed [31:0] start_x;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         glyph;
		logic               alt_font;
		logic signed [31:0] draw_x;
		logic signed [31:0] next_x;
		logic               last;
	} out_item_t;

endpackage

@@ rtl/core/ntdg_mul.sv @@
// ntdg_mul: shared 32x32 multiplier, used for the divide-by-ten digit step
// and for scaling the digit count by the spacing; depends on ntdg_pkg

module ntdg_mul (
	input  logic                        scale,
	input  logic [30:0]                 rest,
	input  logic [ntdg_pkg::CNT_W-1:0]  count,
	input  logic [23:0]                 spacing,
	output logic [30:0]                 quot,
	output logic [3:0]                  rem,
	output logic [31:0]                 prod
);

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] full;
	logic [3:0]  q_ten;

	// operand select
	always_comb begin
		if (scale) begin
			op_a = 32'(count);
			op_b = {8'b0, spacing};
		end else begin
			op_a = {1'b0, rest};
			op_b = ntdg_pkg::RECIP_TEN;
		end
	end

	assign full = op_a * op_b;
	assign prod = full[31:0];
	assign quot = 31'(full[63:ntdg_pkg::RECIP_SHIFT]);

	// remainder lies in 0..9, so only the low nibble of rest - 10*quot matters
	assign q_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign rem   = rest[3:0] - q_ten;

endmodule

@@ rtl/core/number_to_digit_glyphs.sv @@
// number_to_digit_glyphs: top level, register port, sequencer and glyph output
// depends on ntdg_pkg and ntdg_mul

// Turns one non-negative number into a run of digit glyphs, least significant
// first, each with its 16.16 draw position and the position after the run.
// cmd 0 gives a fixed or natural decimal count, cmd 1 four hex nibbles, cmd 2
// the natural decimal count plus a suffix glyph; cmd 3 is taken and dropped.
// The input is stalled from acceptance until the last glyph of the run is taken.
// After acceptance the sequencer finds the natural decimal digits, one per
// ST_DIGITS step on the shared reciprocal multiplier (none in hex mode),
// then in ST_SCALE and ST_ADJUST that same multiplier and a subtractor form
// the end position, then ST_EMIT gives one glyph per output transaction.
// digit_spacing sits at byte address 0 and suffix_gap at 4 on the APB port.

module number_to_digit_glyphs (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ntdg_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// number channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ntdg_pkg::in_item_t            in_data,
	// glyph channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output ntdg_pkg::out_item_t           out_data
);

	ntdg_pkg::state_t state_q, state_nxt;

	logic [23:0]                spacing_q;
	logic [23:0]                gap_q;
	logic [1:0]                 cmd_q;
	logic [30:0]                rest_q;
	logic [3:0]                 want_q;
	logic signed [31:0]         start_x_q;
	logic signed [31:0]         draw_x_q;
	logic signed [31:0]         end_x_q;
	logic [31:0]                prod_q;
	logic [ntdg_pkg::CNT_W-1:0] nat_q;
	logic [ntdg_pkg::CNT_W-1:0] count_q;
	logic [ntdg_pkg::CNT_W-1:0] k_q;
	logic [3:0]                 digit_q [ntdg_pkg::MAX_DIGITS];

	logic                       in_acc;
	logic                       out_acc;
	logic                       cfg_wr;
	logic [30:0]                quot;
	logic [3:0]                 rem;
	logic [31:0]                prod;
	logic [ntdg_pkg::CNT_W-1:0] cnt_sel;
	logic [31:0]                gap_sel;
	logic                       digits_done;
	logic                       is_suffix;
	logic                       is_last;
	logic [3:0]                 glyph;

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;
	assign cfg_wr  = psel & penable & pwrite & pready;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ntdg_pkg::REG_GAP) ? {8'b0, gap_q} : {8'b0, spacing_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= ntdg_pkg::SPACING_RESET;
			gap_q     <= ntdg_pkg::GAP_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == ntdg_pkg::REG_GAP) begin
				gap_q <= pwdata[23:0];
			end else begin
				spacing_q <= pwdata[23:0];
			end
		end
	end

	// shared multiplier
	ntdg_mul u_mul (
		.scale   (state_q == ntdg_pkg::ST_SCALE),
		.rest    (rest_q),
		.count   (cnt_sel),
		.spacing (spacing_q),
		.quot    (quot),
		.rem     (rem),
		.prod    (prod)
	);

	// digit glyph count of the run
	always_comb begin
		if (cmd_q == ntdg_pkg::CMD_HEX) begin
			cnt_sel = ntdg_pkg::CNT_W'(ntdg_pkg::HEX_DIGITS);
		end else if (cmd_q == ntdg_pkg::CMD_DEC && want_q != 4'd0) begin
			if (5'(want_q) > 5'(ntdg_pkg::MAX_DIGITS)) begin
				cnt_sel = ntdg_pkg::CNT_W'(ntdg_pkg::MAX_DIGITS);
			end else begin
				cnt_sel = ntdg_pkg::CNT_W'(want_q);
			end
		end else begin
			cnt_sel = nat_q;
		end
	end

	assign gap_sel     = (cmd_q == ntdg_pkg::CMD_SUFFIX) ? {8'b0, gap_q} : 32'd0;
	assign digits_done = (quot == 31'd0) ||
	                     (nat_q == ntdg_pkg::CNT_W'(ntdg_pkg::MAX_DIGITS - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntdg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ntdg_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_data.cmd == ntdg_pkg::CMD_HEX) begin
						state_nxt = ntdg_pkg::ST_SCALE;
					end else if (in_data.cmd == ntdg_pkg::CMD_DEC ||
					             in_data.cmd == ntdg_pkg::CMD_SUFFIX) begin
						state_nxt = ntdg_pkg::ST_DIGITS;
					end
				end
			end
			ntdg_pkg::ST_DIGITS: begin
				if (digits_done) begin
					state_nxt = ntdg_pkg::ST_SCALE;
				end
			end
			ntdg_pkg::ST_SCALE:  state_nxt = ntdg_pkg::ST_ADJUST;
			ntdg_pkg::ST_ADJUST: state_nxt = ntdg_pkg::ST_EMIT;
			ntdg_pkg::ST_EMIT: begin
				if (out_acc && is_last) begin
					state_nxt = ntdg_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ntdg_pkg::ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ntdg_pkg::ST_IDLE: begin
				if (in_acc) begin
					cmd_q     <= in_data.cmd;
					rest_q    <= in_data.value;
					want_q    <= in_data.digit_count;
					start_x_q <= in_data.start_x;
					draw_x_q  <= in_data.start_x;
					nat_q     <= '0;
					k_q       <= '0;
				end
			end
			ntdg_pkg::ST_DIGITS: begin
				digit_q[nat_q[ntdg_pkg::IDX_W-1:0]] <= rem;
				nat_q  <= nat_q + 1'b1;
				rest_q <= quot;
			end
			ntdg_pkg::ST_SCALE: begin
				count_q <= cnt_sel;
				prod_q  <= prod;
				end_x_q <= start_x_q - $signed(gap_sel);
			end
			ntdg_pkg::ST_ADJUST: begin
				end_x_q <= end_x_q - $signed(prod_q);
				// hex keeps the value for its nibbles
				if (cmd_q == ntdg_pkg::CMD_HEX) begin
					rest_q <= rest_q;
				end
			end
			ntdg_pkg::ST_EMIT: begin
				if (out_acc) begin
					k_q      <= k_q + 1'b1;
					draw_x_q <= draw_x_q - $signed({8'b0, spacing_q});
				end
			end
			default: begin
			end
		endcase
	end

	// glyph selection for the current position in the run
	assign is_suffix = (k_q == count_q);
	assign is_last   = (cmd_q == ntdg_pkg::CMD_SUFFIX) ? is_suffix :
	                   (k_q == ntdg_pkg::CNT_W'(count_q - 1'b1));

	always_comb begin
		if (is_suffix) begin
			glyph = ntdg_pkg::SUFFIX_GLYPH;
		end else if (cmd_q == ntdg_pkg::CMD_HEX) begin
			glyph = 4'(rest_q >> {k_q[1:0], 2'b00});
		end else if (k_q < nat_q) begin
			glyph = digit_q[k_q[ntdg_pkg::IDX_W-1:0]];
		end else begin
			// leading zero of a fixed count
			glyph = 4'd0;
		end
	end

	assign out_valid         = (state_q == ntdg_pkg::ST_EMIT);
	assign out_data.glyph    = glyph;
	assign out_data.alt_font = (cmd_q == ntdg_pkg::CMD_SUFFIX);
	assign out_data.draw_x   = is_suffix ? end_x_q : draw_x_q;
	assign out_data.next_x   = end_x_q;
	assign out_data.last     = is_last;

	assign in_stall = (state_q != ntdg_pkg::ST_IDLE);

endmodule

@@ rtl/core/ntdg_props.sv @@
// ntdg_props: port-level assertions for number_to_digit_glyphs and the bind
// that attaches them; depends on ntdg_pkg

module ntdg_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input ntdg_pkg::out_item_t out_data
);

	// no new number is taken while glyphs of a run are pending
	a_busy_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted during a glyph run");

	// the run ends right after its last glyph transaction
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last) |=> !out_valid)
		else $error("glyph shown after the last one");

	// a run carries one end position and continues until its last glyph
	a_next_x_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.last) |=>
		(out_valid && out_data.next_x == $past(out_data.next_x)))
		else $error("end position changed inside a run");

	// the suffix font only holds decimal digits and the suffix glyph
	a_alt_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.alt_font) |-> (out_data.glyph <= 4'd10))
		else $error("glyph out of range in suffix font");

endmodule

bind number_to_digit_glyphs ntdg_props u_ntdg_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
